// ----- rtl/scp_pkg.sv -----
package scp_pkg;

    // parser states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_AUTO = 3'd1,
        ST_MODE = 3'd2,
        ST_RUM0 = 3'd3,
        ST_RUM1 = 3'd4,
        ST_RUM2 = 3'd5
    } parse_state_t;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_M_UP  = 8'h4D;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_V_UP  = 8'h56;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_M_LO  = 8'h6D;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_V_LO  = 8'h76;

    // hex value offset for letters
    localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

    // architectural state of the parser
    typedef struct packed {
        parse_state_t state;
        logic         auto_flag;
        logic         analog_flag;
        logic         pressure_flag;
        logic         small_staged;
        logic [7:0]   large_staged;
        logic         small_motor;
        logic [7:0]   large_motor;
        logic         report_pending;
        logic         restart_pending;
    } scp_state_t;

    localparam scp_state_t SCP_STATE_RESET = '{
        state:           ST_IDLE,
        auto_flag:       1'b0,
        analog_flag:     1'b1,
        pressure_flag:   1'b0,
        small_staged:    1'b0,
        large_staged:    8'd0,
        small_motor:     1'b0,
        large_motor:     8'd0,
        report_pending:  1'b0,
        restart_pending: 1'b0
    };

    // tick pulses of one item
    typedef struct packed {
        logic report_now;
        logic restart_pad;
    } scp_pulse_t;

    // one ascii hex digit to its value, anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CH_0 && c <= CH_9)
            begin
                v = c - CH_0;
            end
            else if (c >= CH_A_UP && c <= CH_F_UP)
            begin
                v = c - CH_A_UP + HEX_LETTER_OFS;
            end
            else if (c >= CH_A_LO && c <= CH_F_LO)
            begin
                v = c - CH_A_LO + HEX_LETTER_OFS;
            end
            return v[3:0];
        end
    endfunction

endpackage

// ----- rtl/scp_cmd_if.sv -----
interface scp_cmd_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ----- rtl/scp_rsp_if.sv -----
interface scp_rsp_if;
    logic       valid;
    logic       ready;
    logic       report_now;
    logic       restart_pad;
    logic       auto_report;
    logic       analog_mode;
    logic       pressure_mode;
    logic       small_motor_on;
    logic [7:0] large_motor_level;

    modport source (
        output valid, output report_now, output restart_pad, output auto_report,
        output analog_mode, output pressure_mode, output small_motor_on,
        output large_motor_level, input ready
    );
    modport sink (
        input valid, input report_now, input restart_pad, input auto_report,
        input analog_mode, input pressure_mode, input small_motor_on,
        input large_motor_level, output ready
    );
endinterface

// ----- rtl/scp_step.sv -----
module scp_step
    import scp_pkg::*;
(
    input  scp_state_t cur,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output scp_state_t nxt,
    output scp_pulse_t pulse
);

    logic [3:0] nibble;

    assign nibble = hex_value(rx_byte);

    // next state and tick pulses for one item
    always_comb
    begin
        nxt   = cur;
        pulse = '0;
        if (kind == KIND_TICK)
        begin
            // restart wins over report
            if (cur.restart_pending)
            begin
                nxt.auto_flag     = 1'b0;
                nxt.small_motor   = 1'b0;
                nxt.large_motor   = 8'd0;
                pulse.restart_pad = 1'b1;
            end
            else if (cur.report_pending || cur.auto_flag)
            begin
                pulse.report_now = 1'b1;
            end
            nxt.report_pending  = 1'b0;
            nxt.restart_pending = 1'b0;
        end
        else
        begin
            unique case (cur.state)
                ST_IDLE:
                begin
                    // command letter decode, either case
                    unique case (rx_byte) inside
                        CH_A_UP, CH_A_LO:
                        begin
                            nxt.state     = ST_AUTO;
                            nxt.auto_flag = 1'b0;
                        end
                        CH_M_UP, CH_M_LO:
                        begin
                            nxt.state = ST_MODE;
                        end
                        CH_P_UP, CH_P_LO:
                        begin
                            nxt.report_pending = 1'b1;
                        end
                        CH_R_UP, CH_R_LO:
                        begin
                            nxt.restart_pending = 1'b1;
                        end
                        CH_V_UP, CH_V_LO:
                        begin
                            nxt.state        = ST_RUM0;
                            nxt.small_staged = 1'b0;
                            nxt.large_staged = 8'd0;
                        end
                        default:
                        begin
                            nxt.state = ST_IDLE;
                        end
                    endcase
                end
                ST_AUTO:
                begin
                    nxt.auto_flag = (rx_byte == CH_1);
                    nxt.state     = ST_IDLE;
                end
                ST_MODE:
                begin
                    nxt.restart_pending = 1'b1;
                    nxt.analog_flag     = (rx_byte == CH_1) || (rx_byte == CH_2);
                    nxt.pressure_flag   = (rx_byte == CH_2);
                    nxt.state           = ST_IDLE;
                end
                ST_RUM0:
                begin
                    if (rx_byte == CH_NL)
                    begin
                        nxt.state = ST_IDLE;
                    end
                    else
                    begin
                        nxt.small_staged = (rx_byte == CH_1);
                        nxt.state        = ST_RUM1;
                    end
                end
                ST_RUM1:
                begin
                    if (rx_byte == CH_NL)
                    begin
                        nxt.state = ST_IDLE;
                    end
                    else
                    begin
                        nxt.large_staged = cur.large_staged | {nibble, 4'd0};
                        nxt.state        = ST_RUM2;
                    end
                end
                ST_RUM2:
                begin
                    // last digit commits both motors
                    if (rx_byte != CH_NL)
                    begin
                        nxt.large_staged = cur.large_staged | {4'd0, nibble};
                        nxt.small_motor  = cur.small_staged;
                        nxt.large_motor  = cur.large_staged | {4'd0, nibble};
                    end
                    nxt.state = ST_IDLE;
                end
                default:
                begin
                    nxt.state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/serial_command_parser.sv -----
// Serial command parser for a game pad bridge.
// cmd channel: one item per received ascii byte (kind 0) or per end of
// poll batch tick (kind 1); rx_byte is ignored on ticks.
// rsp channel: exactly one item per cmd item, in order, carrying the tick
// pulses (report_now, restart_pad; always 0 for byte items) and the
// settings as they stand after that item.
// Data path: an accepted item is held in the input register until the
// result register is free or being taken, then its result is registered
// into the result register and offered on rsp.
// Throughput: one item per cycle unless rsp stalls; all parsing is a
// single level of next-state logic between the input register and the
// result register. A full result register waiting on the sink does not
// block cmd: one more item is taken into the input register, then
// cmd.ready drops until rsp is taken.
// Reset: parser returns to idle, auto-report off, analog on, pressure off,
// motors off, no request pending, both channels empty.
module serial_command_parser
    import scp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    scp_cmd_if.sink   cmd,
    scp_rsp_if.source rsp
);

    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    scp_state_t st_reg;
    scp_state_t st_next;
    scp_pulse_t pulse;

    logic       out_valid_reg;
    scp_pulse_t out_pulse_reg;
    scp_state_t out_st_reg;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_kind_reg <= cmd.kind;
            in_byte_reg <= cmd.rx_byte;
        end
    end

    // parser logic
    scp_step u_step (
        .cur     (st_reg),
        .kind    (in_kind_reg),
        .rx_byte (in_byte_reg),
        .nxt     (st_next),
        .pulse   (pulse)
    );

    // parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= SCP_STATE_RESET;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pulse_reg <= pulse;
            out_st_reg    <= st_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.report_now        = out_pulse_reg.report_now;
    assign rsp.restart_pad       = out_pulse_reg.restart_pad;
    assign rsp.auto_report       = out_st_reg.auto_flag;
    assign rsp.analog_mode       = out_st_reg.analog_flag;
    assign rsp.pressure_mode     = out_st_reg.pressure_flag;
    assign rsp.small_motor_on    = out_st_reg.small_motor;
    assign rsp.large_motor_level = out_st_reg.large_motor;

    // restart and report never pulse together
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.report_now && rsp.restart_pad))
        else $error("report and restart pulsed in one item");

    // a byte item never produces a pulse
    a_byte_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_BYTE) |=> (!rsp.report_now && !rsp.restart_pad))
        else $error("pulse on a byte item");

    // a restart leaves motors and auto-report cleared
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.restart_pad) |->
            (!rsp.auto_report && !rsp.small_motor_on && rsp.large_motor_level == 8'd0))
        else $error("restart did not clear settings");

    // pending flags are gone after any tick
    a_tick_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_TICK) |=>
            (!st_reg.report_pending && !st_reg.restart_pending))
        else $error("pending request survived a tick");

endmodule
